FILE: hw/rtl/tlpq_pkg.sv
// Shared definitions for the two-level priority queue unit.
// Holds the default sizes, the request action codes and the ring control struct.
// No dependencies.
package tlpq_pkg;

	// Default number of words held per priority class.
	localparam int DEF_CLASS_DEPTH = 16;
	// Default width of a stored data word.
	localparam int DEF_PAYLOAD_WIDTH = 32;

	// Action carried by a request.
	typedef enum logic {
		ACT_ENQUEUE = 1'b0,
		ACT_DEQUEUE = 1'b1
	} action_t;

	// Per-class ring buffer commands for one request.
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

endpackage

FILE: hw/rtl/two_level_priority_queue_unit.sv
// Two-level strict priority queue unit: a high and a low class, each a ring buffer.
// Depends on tlpq_pkg and instantiates tlpq_ring once per class.
//
// The unit takes one request per clock cycle. Each request is an enqueue or a
// dequeue; its result appears in the result register in the cycle after the
// request is taken, and a new request is taken in every cycle that the result
// side does not stall. This is made possible by the per-class registered
// front word: every request only moves ring pointers and reloads that register.
// A dequeue serves the oldest high word if any, else the oldest low word. The
// head word and class counts in a result describe the queue after its request
// and hold steady while the result waits. Stored words have no reset value.
module two_level_priority_queue_unit import tlpq_pkg::*; #(
	parameter int CLASS_DEPTH   = DEF_CLASS_DEPTH,
	parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [PAYLOAD_WIDTH-1:0]         payload,
	input  logic                             high_class,
	// Result channel.
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic                             out_valid,
	output logic [PAYLOAD_WIDTH-1:0]         out_payload,
	output logic                             out_high,
	output logic                             dropped,
	output logic                             head_valid,
	output logic [PAYLOAD_WIDTH-1:0]         head_payload,
	output logic [$clog2(CLASS_DEPTH+1)-1:0] high_count,
	output logic [$clog2(CLASS_DEPTH+1)-1:0] low_count
);

	localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CLASS_DEPTH);

	ring_ctl_t                high_ctl;
	ring_ctl_t                low_ctl;
	logic [PAYLOAD_WIDTH-1:0] high_front;
	logic [PAYLOAD_WIDTH-1:0] low_front;
	logic [CNT_W-1:0]         high_fill;
	logic [CNT_W-1:0]         low_fill;
	logic                     accept;
	logic                     is_deq;
	logic                     high_full;
	logic                     low_full;

	logic                     res_valid_q;
	logic                     out_valid_q;
	logic [PAYLOAD_WIDTH-1:0] out_payload_q;
	logic                     out_high_q;
	logic                     dropped_q;

	// A request is taken unless a finished result is held back.
	assign in_stall = res_valid_q && res_stall;
	assign accept   = in_valid && !in_stall;
	assign is_deq   = (action == ACT_DEQUEUE);

	assign high_full = (high_fill == FULL_CNT);
	assign low_full  = (low_fill == FULL_CNT);

	// Ring commands: enqueue goes to its class, dequeue prefers the high class.
	always_comb begin
		high_ctl.push = accept && !is_deq && high_class;
		low_ctl.push  = accept && !is_deq && !high_class;
		high_ctl.pop  = accept && is_deq && (high_fill != '0);
		low_ctl.pop   = accept && is_deq && (high_fill == '0) && (low_fill != '0);
	end

	tlpq_ring #(
		.DEPTH (CLASS_DEPTH),
		.WIDTH (PAYLOAD_WIDTH)
	) u_high_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (high_ctl),
		.wdata  (payload),
		.front  (high_front),
		.fill   (high_fill)
	);

	tlpq_ring #(
		.DEPTH (CLASS_DEPTH),
		.WIDTH (PAYLOAD_WIDTH)
	) u_low_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (low_ctl),
		.wdata  (payload),
		.front  (low_front),
		.fill   (low_fill)
	);

	// Result handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Dequeue and drop outcome of the request just taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_q <= high_ctl.pop || low_ctl.pop;
			out_high_q  <= high_ctl.pop;
			dropped_q   <= !is_deq && (high_class ? high_full : low_full);
			if (high_ctl.pop) begin
				out_payload_q <= high_front;
			end else if (low_ctl.pop) begin
				out_payload_q <= low_front;
			end else begin
				out_payload_q <= '0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign out_valid   = out_valid_q;
	assign out_payload = out_payload_q;
	assign out_high    = out_high_q;
	assign dropped     = dropped_q;

	// Head and counts follow the ring state, which stays put until the next request.
	assign high_count   = high_fill;
	assign low_count    = low_fill;
	assign head_valid   = (high_fill != '0) || (low_fill != '0);
	assign head_payload = (high_fill != '0) ? high_front :
		((low_fill != '0) ? low_front : '0);

	// No class ever holds more than its depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(high_fill <= FULL_CNT) && (low_fill <= FULL_CNT))
		else $error("class fill exceeds depth");

	// A low word is served only when the high class is empty.
	a_strict_prio: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid && !out_high) |-> (high_count == '0))
		else $error("low word served while high words held");

	// A request never both dequeues and drops.
	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(dropped && out_valid))
		else $error("result both dropped and dequeued");

	// A taken dequeue from a non-empty queue always returns a word.
	a_deq_serves: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_deq && head_valid) |=> (out_valid && res_valid))
		else $error("dequeue from non-empty queue returned nothing");

endmodule

FILE: hw/rtl/tlpq_ring.sv
// Ring buffer for one priority class with a registered front word.
// Depends on tlpq_pkg for the ring control struct.
// The front register always holds the oldest stored word while the ring is not empty.
module tlpq_ring import tlpq_pkg::*; #(
	parameter int DEPTH = DEF_CLASS_DEPTH,
	parameter int WIDTH = DEF_PAYLOAD_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ring_ctl_t                  ctl,
	input  logic [WIDTH-1:0]           wdata,
	output logic [WIDTH-1:0]           front,
	output logic [$clog2(DEPTH+1)-1:0] fill
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] front_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [PTR_W-1:0] rd_ptr_inc;
	logic [PTR_W-1:0] wr_ptr_inc;
	logic [PTR_W-1:0] rd_ptr_next;
	logic             do_push;
	logic             do_pop;

	// A push into a full ring and a pop from an empty ring are ignored.
	assign do_push = ctl.push && (fill_q != FULL_CNT);
	assign do_pop  = ctl.pop && (fill_q != '0);

	// Pointers wrap at the ring depth, which need not be a power of two.
	assign rd_ptr_inc  = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
	assign wr_ptr_inc  = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_ptr_next = do_pop ? rd_ptr_inc : rd_ptr_q;

	// Pointer and fill state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			rd_ptr_q <= rd_ptr_next;
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// Storage write port.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Registered read of the next front word. A push into an empty ring lands
	// on the new read pointer, so the incoming word is forwarded.
	always_ff @(posedge clk) begin
		if (do_push && (wr_ptr_q == rd_ptr_next)) begin
			front_q <= wdata;
		end else begin
			front_q <= mem[rd_ptr_next];
		end
	end

	assign front = front_q;
	assign fill  = fill_q;

endmodule

FILE: test/two_level_priority_queue_unit_tb.sv
// Self-checking testbench for the two-level priority queue unit.
// Drives enqueue and dequeue requests with random idling on both sides and
// checks every result against a queue-based predictor. Depends on tlpq_pkg.
`timescale 1ns / 1ps

module two_level_priority_queue_unit_tb import tlpq_pkg::*;;

	localparam int DEPTH       = DEF_CLASS_DEPTH;
	localparam int WIDTH       = DEF_PAYLOAD_WIDTH;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE_WAIT = 8;

	// One result as the unit reports it.
	typedef struct packed {
		logic             out_valid;
		logic [WIDTH-1:0] out_payload;
		logic             out_high;
		logic             dropped;
		logic             head_valid;
		logic [WIDTH-1:0] head_payload;
		logic [CNT_W-1:0] high_count;
		logic [CNT_W-1:0] low_count;
	} queue_result_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             action;
	logic [WIDTH-1:0] payload;
	logic             high_class;
	logic             res_valid;
	logic             res_stall;
	logic             out_valid;
	logic [WIDTH-1:0] out_payload;
	logic             out_high;
	logic             dropped;
	logic             head_valid;
	logic [WIDTH-1:0] head_payload;
	logic [CNT_W-1:0] high_count;
	logic [CNT_W-1:0] low_count;

	// Predicted contents of each class, oldest word first.
	logic [WIDTH-1:0] high_words[$];
	logic [WIDTH-1:0] low_words[$];
	// Results predicted for accepted requests and not yet seen.
	queue_result_t    pending_results[$];
	queue_result_t    oldest;

	int unsigned mismatches   = 0;
	int unsigned idle_cycles  = 0;
	int unsigned in_idle_pct  = 0;
	int unsigned res_idle_pct = 0;

	two_level_priority_queue_unit #(
		.CLASS_DEPTH  (DEPTH),
		.PAYLOAD_WIDTH(WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.payload     (payload),
		.high_class  (high_class),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_valid   (out_valid),
		.out_payload (out_payload),
		.out_high    (out_high),
		.dropped     (dropped),
		.head_valid  (head_valid),
		.head_payload(head_payload),
		.high_count  (high_count),
		.low_count   (low_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the predicted queue state and return its result.
	function automatic queue_result_t apply_queue_request(action_t act,
			logic [WIDTH-1:0] data, logic is_high);
		queue_result_t r;
		r = '0;
		if (act == ACT_ENQUEUE) begin
			if (is_high) begin
				if (high_words.size() >= DEPTH) r.dropped = 1'b1;
				else high_words.push_back(data);
			end else begin
				if (low_words.size() >= DEPTH) r.dropped = 1'b1;
				else low_words.push_back(data);
			end
		end else if (high_words.size() > 0) begin
			r.out_valid   = 1'b1;
			r.out_high    = 1'b1;
			r.out_payload = high_words.pop_front();
		end else if (low_words.size() > 0) begin
			r.out_valid   = 1'b1;
			r.out_payload = low_words.pop_front();
		end
		// The head is the word the next dequeue would serve.
		if (high_words.size() > 0) begin
			r.head_valid   = 1'b1;
			r.head_payload = high_words[0];
		end else if (low_words.size() > 0) begin
			r.head_valid   = 1'b1;
			r.head_payload = low_words[0];
		end
		r.high_count = CNT_W'(high_words.size());
		r.low_count  = CNT_W'(low_words.size());
		return r;
	endfunction

	function automatic void check_field(string name, logic [WIDTH-1:0] want,
			logic [WIDTH-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Send one request, with an optional idle burst before it, and record its
	// expected result once it is accepted. Valid stays high afterward so that
	// back-to-back requests never lower and raise it in the same step.
	task automatic send_request(action_t act, logic [WIDTH-1:0] data, logic is_high);
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		payload    <= data;
		high_class <= is_high;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_queue_request(act, data, is_high));
	endtask

	// Extreme words in both classes, strict priority, FIFO order within a
	// class, and dequeues on an empty queue at both ends.
	task automatic test_directed_order();
		send_request(ACT_DEQUEUE, '1, 1'b1);
		send_request(ACT_ENQUEUE, '0, 1'b0);
		send_request(ACT_ENQUEUE, '1, 1'b0);
		send_request(ACT_ENQUEUE, '1, 1'b1);
		send_request(ACT_ENQUEUE, '0, 1'b1);
		send_request(ACT_ENQUEUE, 32'h5A5A_A5A5, 1'b0);
		send_request(ACT_ENQUEUE, 32'hA5A5_5A5A, 1'b1);
		repeat (8) send_request(ACT_DEQUEUE, $urandom(), 1'($urandom_range(0, 1)));
	endtask

	// Random traffic in segments, each with its own mix: filling one class past
	// full, filling both, draining past empty, or balanced. With idling enabled
	// each segment also picks how often each side pauses, zero included.
	task automatic test_random_traffic(int unsigned n_requests, bit with_idle);
		int unsigned sent;
		int unsigned seg_len;
		int unsigned enq_pct;
		int unsigned high_pct;
		action_t     act;
		logic [WIDTH-1:0] data;
		sent = 0;
		while (sent < n_requests) begin
			seg_len = $urandom_range(8, 48);
			// The last segment stops at the requested count.
			if (seg_len > n_requests - sent) seg_len = n_requests - sent;
			case ($urandom_range(0, 4))
				0: begin
					enq_pct  = 95;
					high_pct = 100;
				end
				1: begin
					enq_pct  = 95;
					high_pct = 0;
				end
				2: begin
					enq_pct  = 85;
					high_pct = 50;
				end
				3: begin
					enq_pct  = 10;
					high_pct = 50;
				end
				default: begin
					enq_pct  = 50;
					high_pct = 50;
				end
			endcase
			in_idle_pct  = with_idle ? 15 * $urandom_range(0, 2) : 0;
			res_idle_pct = with_idle ? 15 * $urandom_range(0, 2) : 0;
			repeat (seg_len) begin
				act  = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
				data = $urandom();
				// Now and then an all-zero or all-one word.
				if ($urandom_range(0, 15) == 0) data = $urandom_range(0, 1) ? '1 : '0;
				send_request(act, data, 1'($urandom_range(0, 99) < high_pct));
				sent++;
			end
		end
	endtask

	// Stall the result side in random bursts.
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_idle_pct != 0 && $urandom_range(0, 99) < res_idle_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("result arrived with no request waiting for it");
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("out_valid", WIDTH'(oldest.out_valid), WIDTH'(out_valid));
				check_field("out_payload", oldest.out_payload, out_payload);
				check_field("out_high", WIDTH'(oldest.out_high), WIDTH'(out_high));
				check_field("dropped", WIDTH'(oldest.dropped), WIDTH'(dropped));
				check_field("head_valid", WIDTH'(oldest.head_valid), WIDTH'(head_valid));
				check_field("head_payload", oldest.head_payload, head_payload);
				check_field("high_count", WIDTH'(oldest.high_count), WIDTH'(high_count));
				check_field("low_count", WIDTH'(oldest.low_count), WIDTH'(low_count));
			end
		end
	end

	// End the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_ENQUEUE;
		payload    <= '0;
		high_class <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_order();
		test_random_traffic(900, 1'b1);
		test_random_traffic(140, 1'b0);

		// Drain the remaining results, then watch for strays.
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/tlpq_pkg.sv
hw/rtl/tlpq_ring.sv
hw/rtl/two_level_priority_queue_unit.sv
test/two_level_priority_queue_unit_tb.sv
